FILE: rtl/drc_pkg.sv
// Package with constants, register codes and shared types of the registration core.
`default_nettype none
package drc_pkg;

   localparam int MAX_IMAGE_SIDE = 4096;
   localparam int COEF_FRAC_BITS = 16;

   localparam int QUOT_BITS    = $clog2(MAX_IMAGE_SIDE);
   localparam int COEF_W       = 32;
   localparam int PIX_W        = 12;
   localparam int DEPTH_W      = 16;
   localparam int SIZE_W       = 13;
   localparam int CSR_IDX_W    = 8;
   localparam int CSR_DATA_W   = 64;
   localparam int PROD_W       = COEF_W + PIX_W + 1;
   localparam int SUM_W        = PROD_W + 2;
   localparam int P_W          = 64;
   localparam int NUM_W        = P_W + 1;
   localparam int N_W          = NUM_W + 2;
   localparam int D2_W         = NUM_W + 1;
   localparam int REM_W        = D2_W + QUOT_BITS;
   localparam int FRONT_STAGES = 7;
   localparam int PIPE_STAGES  = FRONT_STAGES + QUOT_BITS;

   localparam logic [COEF_W-1:0] ONE_Q = COEF_W'(1) << COEF_FRAC_BITS;
   localparam logic [CSR_DATA_W-1:0] COEF_DIAG_RESET = {ONE_Q, {COEF_W{1'b0}}};
   localparam logic [SIZE_W-1:0] WIDTH_RESET  = SIZE_W'(640);
   localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(480);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_H00_H01   = 8'd0,
      REG_H02_H10   = 8'd1,
      REG_H11_H12   = 8'd2,
      REG_H20_H21   = 8'd3,
      REG_H22_E0    = 8'd4,
      REG_E1_E2     = 8'd5,
      REG_WIDTH     = 8'd6,
      REG_HEIGHT    = 8'd7
   } csr_idx_type;

   // Matrix entry h[3*row+col], translation e[row].
   typedef struct packed {
      logic [8:0][COEF_W-1:0] h;
      logic [2:0][COEF_W-1:0] e;
      logic [SIZE_W-1:0]      width;
      logic [SIZE_W-1:0]      height;
   } cfg_type;

   typedef struct packed {
      logic [1:0][REM_W-1:0]     rem;
      logic [D2_W-1:0]           d2;
      logic [1:0][QUOT_BITS-1:0] quo;
      logic [1:0]                ok;
      logic [DEPTH_W-1:0]        depth;
   } div_type;

   typedef struct packed {
      logic               write_valid;
      logic [PIX_W-1:0]   target_column;
      logic [PIX_W-1:0]   target_row;
      logic [DEPTH_W-1:0] depth_value;
   } rsp_type;

endpackage
`default_nettype wire

FILE: rtl/drc_if.sv
// Channel interfaces of the registration core: pixel input, write command output, CSR.
`default_nettype none
interface drc_req_if import drc_pkg::*; ;
   logic               valid;
   logic               ready;
   logic [PIX_W-1:0]   pixel_column;
   logic [PIX_W-1:0]   pixel_row;
   logic [DEPTH_W-1:0] depth_sample;
   modport source (output valid, pixel_column, pixel_row, depth_sample, input ready);
   modport sink   (input valid, pixel_column, pixel_row, depth_sample, output ready);
endinterface

interface drc_rsp_if import drc_pkg::*; ;
   logic               valid;
   logic               ready;
   logic               write_valid;
   logic [PIX_W-1:0]   target_column;
   logic [PIX_W-1:0]   target_row;
   logic [DEPTH_W-1:0] depth_value;
   modport source (output valid, write_valid, target_column, target_row, depth_value,
                   input ready);
   modport sink   (input valid, write_valid, target_column, target_row, depth_value,
                   output ready);
endinterface

interface drc_csr_if import drc_pkg::*; ;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/drc_csr.sv
// Configuration registers of the registration core.
`default_nettype none
module drc_csr import drc_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   drc_csr_if.sink     csr,
   output cfg_type     cfg
);

   logic [5:0][CSR_DATA_W-1:0] coef_ff;
   logic [SIZE_W-1:0]          width_ff;
   logic [SIZE_W-1:0]          height_ff;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff[0] <= COEF_DIAG_RESET;
         coef_ff[1] <= '0;
         coef_ff[2] <= COEF_DIAG_RESET;
         coef_ff[3] <= '0;
         coef_ff[4] <= COEF_DIAG_RESET;
         coef_ff[5] <= '0;
         width_ff   <= WIDTH_RESET;
         height_ff  <= HEIGHT_RESET;
      end else if (csr.valid) begin
         unique case (csr.index)
            REG_H00_H01: coef_ff[0] <= csr.data;
            REG_H02_H10: coef_ff[1] <= csr.data;
            REG_H11_H12: coef_ff[2] <= csr.data;
            REG_H20_H21: coef_ff[3] <= csr.data;
            REG_H22_E0:  coef_ff[4] <= csr.data;
            REG_E1_E2:   coef_ff[5] <= csr.data;
            REG_WIDTH:   width_ff   <= csr.data[SIZE_W-1:0];
            REG_HEIGHT:  height_ff  <= csr.data[SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cfg.h[0]   = coef_ff[0][63:32];
      cfg.h[1]   = coef_ff[0][31:0];
      cfg.h[2]   = coef_ff[1][63:32];
      cfg.h[3]   = coef_ff[1][31:0];
      cfg.h[4]   = coef_ff[2][63:32];
      cfg.h[5]   = coef_ff[2][31:0];
      cfg.h[6]   = coef_ff[3][63:32];
      cfg.h[7]   = coef_ff[3][31:0];
      cfg.h[8]   = coef_ff[4][63:32];
      cfg.e[0]   = coef_ff[4][31:0];
      cfg.e[1]   = coef_ff[5][63:32];
      cfg.e[2]   = coef_ff[5][31:0];
      cfg.width  = width_ff;
      cfg.height = height_ff;
   end

endmodule
`default_nettype wire

FILE: rtl/drc_proj.sv
// Projection front end: products, sums, depth scaling, sign normalization and range check.
`default_nettype none
module drc_proj import drc_pkg::*; (
   input  wire logic               clock,
   input  wire logic               en,
   input  wire logic [PIX_W-1:0]   pixel_column,
   input  wire logic [PIX_W-1:0]   pixel_row,
   input  wire logic [DEPTH_W-1:0] depth_sample,
   input  wire cfg_type            cfg,
   output div_type                 div_out
);

   logic [PIX_W-1:0]          u_ff, v_ff;
   logic [5:0][DEPTH_W-1:0]   d_ff;
   logic signed [PROD_W-1:0]  prod_ff [6];
   logic signed [PROD_W-1:0]  prod_in [6];
   logic signed [SUM_W-1:0]   sum_ff [3];
   logic signed [SUM_W-1:0]   sum_in [3];
   logic signed [P_W-1:0]     mul_ff [3];
   logic signed [P_W-1:0]     mul_in [3];
   logic signed [P_W-1:0]     p_ff [3];
   logic signed [P_W-1:0]     p_in [3];
   logic signed [N_W-1:0]     n_ff [2];
   logic signed [N_W-1:0]     n_in [2];
   logic [D2_W-1:0]           d2_ff, d2_in;
   logic                      nz_ff;
   logic signed [NUM_W-1:0]   num [2];
   logic signed [NUM_W-1:0]   den;
   logic signed [DEPTH_W:0]   ds;
   logic signed [PIX_W:0]     us, vs;
   div_type                   out_ff, out_in;

   assign us = $signed({1'b0, u_ff});
   assign vs = $signed({1'b0, v_ff});
   assign ds = $signed({1'b0, d_ff[2]});

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         prod_in[2*r]   = $signed(cfg.h[3*r])   * us;
         prod_in[2*r+1] = $signed(cfg.h[3*r+1]) * vs;
         sum_in[r] = SUM_W'(prod_ff[2*r]) + SUM_W'(prod_ff[2*r+1])
                   + SUM_W'($signed(cfg.h[3*r+2]));
         mul_in[r] = sum_ff[r] * ds;
         p_in[r]   = mul_ff[r] + P_W'($signed(cfg.e[r]));
      end
      // Flip signs so the divisor is positive, then fold the half-step rounding in.
      den = p_ff[2][P_W-1] ? -NUM_W'(p_ff[2]) : NUM_W'(p_ff[2]);
      for (int r = 0; r < 2; r++) begin
         num[r]  = p_ff[2][P_W-1] ? -NUM_W'(p_ff[r]) : NUM_W'(p_ff[r]);
         n_in[r] = (N_W'(num[r]) <<< 1) + N_W'(den);
      end
      d2_in = D2_W'($unsigned(den)) << 1;
      out_in.d2    = d2_ff;
      out_in.quo   = '0;
      out_in.depth = d_ff[5];
      for (int r = 0; r < 2; r++) begin
         out_in.rem[r] = REM_W'($unsigned(n_ff[r]));
         out_in.ok[r]  = nz_ff && !n_ff[r][N_W-1]
                      && (REM_W'($unsigned(n_ff[r])) < (REM_W'(d2_ff) << QUOT_BITS));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         u_ff    <= pixel_column;
         v_ff    <= pixel_row;
         d_ff[0] <= depth_sample;
         for (int k = 1; k < 6; k++) d_ff[k] <= d_ff[k-1];
         prod_ff <= prod_in;
         sum_ff  <= sum_in;
         mul_ff  <= mul_in;
         p_ff    <= p_in;
         n_ff    <= n_in;
         d2_ff   <= d2_in;
         nz_ff   <= (p_ff[2] != '0);
         out_ff  <= out_in;
      end
   end

   assign div_out = out_ff;

endmodule
`default_nettype wire

FILE: rtl/drc_div.sv
// Pipelined restoring divider: one quotient bit per stage for column and row together.
`default_nettype none
module drc_div import drc_pkg::*; (
   input  wire logic    clock,
   input  wire logic    en,
   input  wire div_type div_in,
   output div_type      div_out
);

   div_type stage_ff [QUOT_BITS];

   for (genvar i = 0; i < QUOT_BITS; i++) begin : g_step
      localparam int BIT = QUOT_BITS - 1 - i;
      div_type src, nxt;
      logic [REM_W-1:0] shifted;

      if (i == 0) begin : g_first
         assign src = div_in;
      end else begin : g_next
         assign src = stage_ff[i-1];
      end

      always_comb begin
         nxt     = src;
         shifted = REM_W'(src.d2) << BIT;
         for (int r = 0; r < 2; r++) begin
            if (src.rem[r] >= shifted) begin
               nxt.rem[r]      = src.rem[r] - shifted;
               nxt.quo[r][BIT] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            stage_ff[i] <= nxt;
         end
      end
   end

   assign div_out = stage_ff[QUOT_BITS-1];

endmodule
`default_nettype wire

FILE: rtl/depth_to_color_registration_core.sv
// Top level of the depth-to-colour registration core.
//
//   channel | direction | fields                                           | handshake
//   req     | in        | pixel_column, pixel_row, depth_sample            | valid/ready
//   rsp     | out       | write_valid, target_column, target_row, depth    | valid/ready
//   csr     | in        | index, data                                      | valid/ready
//
// One pixel transaction is accepted every cycle while the output buffer is not full.
// On its way to the port the write command passes the input register, six front stages
// (products, sums, depth multiply, translation add, sign fold, range check), one stage
// per quotient bit of the divider, and the output register. Synchronous reset clears
// all valid bits and loads the register defaults. The whole pipeline advances on one
// enable that drops only when the two-entry output buffer is full, so a stalled result
// waits while one more transaction can still land in the skid entry.
`default_nettype none
module depth_to_color_registration_core import drc_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   drc_req_if.sink   req_port,
   drc_rsp_if.source rsp_port,
   drc_csr_if.sink   csr_port
);

   cfg_type                  cfg;
   div_type                  front_out, div_out;
   logic [PIPE_STAGES-1:0]   vld_ff, vld_in;
   logic                     en;
   rsp_type                  result;
   rsp_type                  out_ff, out_in, skid_ff, skid_in;
   logic                     out_vld_ff, out_vld_in, skid_vld_ff, skid_vld_in;
   logic                     incoming, take;

   drc_csr u_csr (
      .clock (clock),
      .reset (reset),
      .csr   (csr_port),
      .cfg   (cfg)
   );

   drc_proj u_proj (
      .clock        (clock),
      .en           (en),
      .pixel_column (req_port.pixel_column),
      .pixel_row    (req_port.pixel_row),
      .depth_sample (req_port.depth_sample),
      .cfg          (cfg),
      .div_out      (front_out)
   );

   drc_div u_div (
      .clock   (clock),
      .en      (en),
      .div_in  (front_out),
      .div_out (div_out)
   );

   // The pipeline only stops when the skid entry holds a result.
   assign en             = !skid_vld_ff;
   assign req_port.ready = en;
   assign vld_in         = {vld_ff[PIPE_STAGES-2:0], req_port.valid};

   // Final bounds check: quotients are below the maximum side by construction,
   // so comparing against the raw 13-bit size also covers oversized settings.
   always_comb begin
      result.write_valid = div_out.ok[0] && div_out.ok[1]
                        && ({1'b0, div_out.quo[0]} < cfg.width)
                        && ({1'b0, div_out.quo[1]} < cfg.height);
      result.target_column = result.write_valid ? div_out.quo[0] : '0;
      result.target_row    = result.write_valid ? div_out.quo[1] : '0;
      result.depth_value   = result.write_valid ? div_out.depth  : '0;
   end

   assign incoming = en && vld_ff[PIPE_STAGES-1];
   assign take     = out_vld_ff && rsp_port.ready;

   always_comb begin
      out_in      = out_ff;
      out_vld_in  = out_vld_ff;
      skid_in     = skid_ff;
      skid_vld_in = skid_vld_ff;
      if (skid_vld_ff) begin
         if (take) begin
            out_in      = skid_ff;
            skid_vld_in = 1'b0;
         end
      end else if (incoming) begin
         if (!out_vld_ff || take) begin
            out_in     = result;
            out_vld_in = 1'b1;
         end else begin
            skid_in     = result;
            skid_vld_in = 1'b1;
         end
      end else if (take) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff      <= '0;
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         if (en) vld_ff <= vld_in;
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_port.valid         = out_vld_ff;
   assign rsp_port.write_valid   = out_ff.write_valid;
   assign rsp_port.target_column = out_ff.target_column;
   assign rsp_port.target_row    = out_ff.target_row;
   assign rsp_port.depth_value   = out_ff.depth_value;

endmodule
`default_nettype wire

FILE: rtl/drc_checker.sv
// Port-level checker of the registration core and its bind statement.
`default_nettype none
module drc_checker import drc_pkg::*; (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_ready,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic               write_valid,
   input wire logic [PIX_W-1:0]   target_column,
   input wire logic [PIX_W-1:0]   target_row,
   input wire logic [DEPTH_W-1:0] depth_value
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(write_valid)
         && $stable(target_column) && $stable(target_row) && $stable(depth_value))
      else $error("stalled write command changed");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !write_valid |-> target_column == '0 && target_row == '0
         && depth_value == '0)
      else $error("rejected write command carries nonzero fields");

   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("pipeline not empty after reset");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input stalled with no waiting result");

endmodule

bind depth_to_color_registration_core drc_checker u_drc_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_port.ready),
   .rsp_valid     (rsp_port.valid),
   .rsp_ready     (rsp_port.ready),
   .write_valid   (rsp_port.write_valid),
   .target_column (rsp_port.target_column),
   .target_row    (rsp_port.target_row),
   .depth_value   (rsp_port.depth_value)
);
`default_nettype wire

FILE: tb/tb_depth_to_color_registration_core.sv
// Self-checking testbench of the depth-to-colour registration core.
`timescale 1ns / 1ps
module tb_depth_to_color_registration_core;
   import drc_pkg::*;

   // The run is bounded by this many clock cycles; the slowest correct run is far shorter.
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 2 * PIPE_STAGES + 8;
   localparam int RANDOM_PHASES = 6;
   localparam int ITEMS_PER_PHASE = 315;
   localparam logic [31:0] Q_ONE = 32'h0001_0000;
   localparam logic [31:0] Q_HALF = 32'h0000_8000;
   localparam logic [31:0] Q_MINUS_ONE = 32'hFFFF_0000;

   logic clock;
   logic reset;

   drc_req_if req_if ();
   drc_rsp_if rsp_if ();
   drc_csr_if csr_if ();

   depth_to_color_registration_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_if),
      .rsp_port (rsp_if),
      .csr_port (csr_if)
   );

   // Shadow copy of the configuration registers, updated on each write to a decoded register.
   logic [CSR_DATA_W-1:0] coef_shadow [6];
   logic [SIZE_W-1:0]     width_shadow;
   logic [SIZE_W-1:0]     height_shadow;

   // Write commands that the core still owes, oldest first.
   rsp_type pending_writes [$];
   // For each pixel handed to the driver: whether a hand-typed result overrides the predictor.
   bit      typed_flag_q [$];
   rsp_type typed_rsp_q [$];

   int mismatch_count;
   int cycle_count;
   int send_idle_pct;
   int recv_idle_pct;

   typedef struct {
      logic [PIX_W-1:0]   col;
      logic [PIX_W-1:0]   row;
      logic [DEPTH_W-1:0] depth;
      bit                 typed;
      rsp_type            rsp;
   } pixel_row_type;

   // Rounds num/den to nearest with ties toward plus infinity; den is nonzero.
   function automatic longint round_half_up(longint num, longint den);
      longint n2;
      longint d2;
      longint q;
      if (den < 0) begin
         num = -num;
         den = -den;
      end
      n2 = 2 * num + den;
      d2 = 2 * den;
      q = n2 / d2;
      if ((n2 % d2) != 0 && n2 < 0) begin
         q = q - 1;
      end
      return q;
   endfunction

   function automatic longint coef_hi(logic [CSR_DATA_W-1:0] r);
      return longint'($signed(r[63:32]));
   endfunction

   function automatic longint coef_lo(logic [CSR_DATA_W-1:0] r);
      return longint'($signed(r[31:0]));
   endfunction

   // Reprojects one depth pixel with the shadow configuration and forms the write command.
   function automatic rsp_type project_pixel(logic [PIX_W-1:0] col, logic [PIX_W-1:0] row,
                                             logic [DEPTH_W-1:0] depth);
      longint u;
      longint v;
      longint d;
      longint p0;
      longint p1;
      longint p2;
      longint tc;
      longint tr;
      longint w;
      longint h;
      rsp_type r;
      u = longint'(col);
      v = longint'(row);
      d = longint'(depth);
      p0 = d * (coef_hi(coef_shadow[0]) * u + coef_lo(coef_shadow[0]) * v
                + coef_hi(coef_shadow[1])) + coef_lo(coef_shadow[4]);
      p1 = d * (coef_lo(coef_shadow[1]) * u + coef_hi(coef_shadow[2]) * v
                + coef_lo(coef_shadow[2])) + coef_hi(coef_shadow[5]);
      p2 = d * (coef_hi(coef_shadow[3]) * u + coef_lo(coef_shadow[3]) * v
                + coef_hi(coef_shadow[4])) + coef_lo(coef_shadow[5]);
      w = (width_shadow > MAX_IMAGE_SIDE) ? MAX_IMAGE_SIDE : longint'(width_shadow);
      h = (height_shadow > MAX_IMAGE_SIDE) ? MAX_IMAGE_SIDE : longint'(height_shadow);
      r = '0;
      if (p2 != 0) begin
         tc = round_half_up(p0, p2);
         tr = round_half_up(p1, p2);
         if (tc >= 0 && tc < w && tr >= 0 && tr < h) begin
            r.write_valid = 1'b1;
            r.target_column = tc[PIX_W-1:0];
            r.target_row = tr[PIX_W-1:0];
            r.depth_value = depth;
         end
      end
      return r;
   endfunction

   // Clock generation: 4 ns period.
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Cycle counter and watchdog. A hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("depth_to_color_registration_core verification failed");
         $finish;
      end
   end

   // Pixel monitor. It runs in the active region of the edge, so it sees the handshake
   // signals as they were just before the edge. Each accepted pixel transaction gets its
   // expected write command, typed by hand for a few directed rows, otherwise predicted.
   always @(posedge clock) begin
      bit      typed;
      rsp_type typed_rsp;
      if (!reset && req_if.valid && req_if.ready) begin
         typed = typed_flag_q.pop_front();
         typed_rsp = typed_rsp_q.pop_front();
         if (typed) begin
            pending_writes.push_back(typed_rsp);
         end else begin
            pending_writes.push_back(project_pixel(req_if.pixel_column, req_if.pixel_row,
                                                   req_if.depth_sample));
         end
      end
   end

   // Write command monitor: every accepted result is compared with the oldest expectation.
   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got.write_valid = rsp_if.write_valid;
         got.target_column = rsp_if.target_column;
         got.target_row = rsp_if.target_row;
         got.depth_value = rsp_if.depth_value;
         if (pending_writes.size() == 0) begin
            mismatch_count <= mismatch_count + 1;
            if (mismatch_count < 10) begin
               $display("unexpected write command: valid %0d col %0d row %0d depth %0d",
                        got.write_valid, got.target_column, got.target_row,
                        got.depth_value);
            end
         end else begin
            want = pending_writes.pop_front();
            if (got.write_valid !== want.write_valid
                || got.target_column !== want.target_column
                || got.target_row !== want.target_row
                || got.depth_value !== want.depth_value) begin
               mismatch_count <= mismatch_count + 1;
               if (mismatch_count < 10) begin
                  $display("write command mismatch: expected valid %0d col %0d row %0d depth %0d",
                           want.write_valid, want.target_column, want.target_row,
                           want.depth_value);
                  $display("                          actual valid %0d col %0d row %0d depth %0d",
                           got.write_valid, got.target_column, got.target_row,
                           got.depth_value);
               end
            end
         end
      end
   end

   // The receiver stalls at random, at the rate chosen for the current phase.
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Hands one pixel transaction to the core and holds it until it is accepted.
   // The valid stays high into the next pixel when no idle cycle falls in between.
   task automatic send_pixel(logic [PIX_W-1:0] col, logic [PIX_W-1:0] row,
                             logic [DEPTH_W-1:0] depth, bit typed, rsp_type typed_rsp);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      typed_flag_q.push_back(typed);
      typed_rsp_q.push_back(typed_rsp);
      req_if.valid <= 1'b1;
      req_if.pixel_column <= col;
      req_if.pixel_row <= row;
      req_if.depth_sample <= depth;
      do begin
         @(posedge clock);
      end while (!req_if.ready);
   endtask

   // Lets every outstanding write command come back before the configuration changes.
   task automatic wait_idle();
      req_if.valid <= 1'b0;
      while (pending_writes.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Writes one register; the shadow copy follows only indexes that the core decodes.
   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data <= value;
      do begin
         @(posedge clock);
      end while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      if (idx < REG_WIDTH) begin
         coef_shadow[idx[2:0]] = value;
      end else if (idx == REG_WIDTH) begin
         width_shadow = value[SIZE_W-1:0];
      end else if (idx == REG_HEIGHT) begin
         height_shadow = value[SIZE_W-1:0];
      end
   endtask

   // A signed value in [-span, span], as a 32-bit word.
   function automatic logic [31:0] small_q(int unsigned span);
      return 32'($signed($urandom_range(2 * span)) - $signed(span));
   endfunction

   // Loads a configuration for one random phase. Most phases use a near-identity
   // transform with a mild perspective term, so that many targets land inside the image;
   // a few phases use the coefficient extremes, fully random words, or odd image sizes.
   task automatic load_phase_config(int ph);
      logic [31:0] h00;
      logic [31:0] h11;
      logic [31:0] h22;
      h00 = Q_ONE + small_q(1 << 13);
      h11 = Q_ONE + small_q(1 << 13);
      h22 = Q_ONE + small_q(1 << 12);
      case (ph)
         1: begin
            // Coefficient extremes; a zero width turns every command invalid.
            write_csr(REG_H00_H01, {32'h7FFF_FFFF, 32'h8000_0000});
            write_csr(REG_H02_H10, {32'h8000_0000, 32'h7FFF_FFFF});
            write_csr(REG_H11_H12, {32'h7FFF_FFFF, 32'h8000_0000});
            write_csr(REG_H20_H21, {32'h8000_0000, 32'h7FFF_FFFF});
            write_csr(REG_H22_E0, {32'h7FFF_FFFF, 32'h8000_0000});
            write_csr(REG_E1_E2, {32'h7FFF_FFFF, 32'h8000_0000});
            write_csr(REG_WIDTH, 64'd0);
            write_csr(REG_HEIGHT, 64'd4096);
         end
         3: begin
            // Fully random words, including sizes above the largest image side.
            write_csr(REG_H00_H01, {$urandom, $urandom});
            write_csr(REG_H02_H10, {$urandom, $urandom});
            write_csr(REG_H11_H12, {$urandom, $urandom});
            write_csr(REG_H20_H21, {$urandom, $urandom});
            write_csr(REG_H22_E0, {$urandom, $urandom});
            write_csr(REG_E1_E2, {$urandom, $urandom});
            write_csr(REG_WIDTH, {$urandom, $urandom});
            write_csr(REG_HEIGHT, {$urandom, $urandom});
         end
         default: begin
            write_csr(REG_H00_H01, {h00, small_q(1 << 13)});
            write_csr(REG_H02_H10, {small_q(200 << 16), small_q(1 << 13)});
            write_csr(REG_H11_H12, {h11, small_q(200 << 16)});
            write_csr(REG_H20_H21, {small_q(4), small_q(4)});
            write_csr(REG_H22_E0, {h22, small_q(1 << 22)});
            write_csr(REG_E1_E2, {small_q(1 << 22), small_q(1 << 14)});
            if (ph == 0) begin
               write_csr(REG_WIDTH, 64'd4096);
               write_csr(REG_HEIGHT, 64'd8191);
            end else if (ph == 2) begin
               write_csr(REG_WIDTH, 64'd1);
               write_csr(REG_HEIGHT, 64'd1);
            end else begin
               write_csr(REG_WIDTH, 64'($urandom_range(4096, 1)));
               write_csr(REG_HEIGHT, 64'($urandom_range(4096, 1)));
            end
         end
      endcase
      // An index outside the register map must leave everything unchanged.
      write_csr(CSR_IDX_W'($urandom_range(255, 8)), {$urandom, $urandom});
   endtask

   // Directed rows. The first group runs on the reset configuration, where the transform
   // is the identity, so the result can be typed in. The second group runs with
   // H00 = 0.5 and H02 = -1.0 to hit rounding ties on both sides of zero.
   localparam int N_DIRECTED = 18;
   localparam int TIE_START = 12;
   pixel_row_type directed [N_DIRECTED];

   initial begin
      directed[0]  = '{0, 0, 0, 1'b1, '0};                        // zero divisor
      directed[1]  = '{10, 20, 5, 1'b1, '{1'b1, 10, 20, 5}};
      directed[2]  = '{0, 0, 1, 1'b1, '{1'b1, 0, 0, 1}};
      directed[3]  = '{639, 479, 16'hFFFF, 1'b1, '{1'b1, 639, 479, 16'hFFFF}};
      directed[4]  = '{640, 0, 1, 1'b1, '0};                      // right of the image
      directed[5]  = '{0, 480, 1, 1'b1, '0};                      // below the image
      directed[6]  = '{4095, 4095, 16'hFFFF, 1'b1, '0};
      directed[7]  = '{4095, 0, 1, 1'b1, '0};
      directed[8]  = '{12'hAAA, 12'h155, 16'h5555, 1'b1, '0};
      directed[9]  = '{12'h155, 12'h0AA, 16'hAAAA, 1'b1, '{1'b1, 12'h155, 12'h0AA, 16'hAAAA}};
      directed[10] = '{0, 4095, 0, 1'b1, '0};
      directed[11] = '{1, 1, 16'h8000, 1'b1, '{1'b1, 1, 1, 16'h8000}};
      directed[12] = '{1, 0, 1, 1'b0, '0};                        // tie at -0.5
      directed[13] = '{3, 0, 1, 1'b0, '0};                        // tie at +0.5
      directed[14] = '{5, 7, 3, 1'b0, '0};
      directed[15] = '{2, 2, 16'hFFFF, 1'b0, '0};
      directed[16] = '{4095, 100, 2, 1'b0, '0};
      directed[17] = '{6, 0, 0, 1'b0, '0};
   end

   // Main stimulus sequence.
   initial begin
      logic [PIX_W-1:0]   c;
      logic [PIX_W-1:0]   r;
      logic [DEPTH_W-1:0] d;
      mismatch_count = 0;
      cycle_count = 0;
      send_idle_pct = 15;
      recv_idle_pct = 47;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.pixel_column = '0;
      req_if.pixel_row = '0;
      req_if.depth_sample = '0;
      csr_if.valid = 1'b0;
      csr_if.index = '0;
      csr_if.data = '0;
      // Shadow copy starts at the reset defaults of the core.
      coef_shadow[0] = COEF_DIAG_RESET;
      coef_shadow[1] = '0;
      coef_shadow[2] = COEF_DIAG_RESET;
      coef_shadow[3] = '0;
      coef_shadow[4] = COEF_DIAG_RESET;
      coef_shadow[5] = '0;
      width_shadow = WIDTH_RESET;
      height_shadow = HEIGHT_RESET;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < N_DIRECTED; i++) begin
         if (i == TIE_START) begin
            wait_idle();
            write_csr(REG_H00_H01, {Q_HALF, 32'h0});
            write_csr(REG_H02_H10, {Q_MINUS_ONE, 32'h0});
         end
         send_pixel(directed[i].col, directed[i].row, directed[i].depth,
                    directed[i].typed, directed[i].rsp);
      end

      // Random phases. Receiver-heavy idling first, then sender-heavy, then none.
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         wait_idle();
         load_phase_config(ph);
         send_idle_pct = (ph < 2) ? 15 : (ph < 4) ? 47 : 0;
         recv_idle_pct = (ph < 2) ? 47 : (ph < 4) ? 15 : 0;
         for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
            // Most pixels sit inside a typical sensor frame; some span the full range.
            if ($urandom_range(3) == 0) begin
               c = PIX_W'($urandom);
               r = PIX_W'($urandom);
               d = DEPTH_W'($urandom);
            end else begin
               c = PIX_W'($urandom_range(639));
               r = PIX_W'($urandom_range(479));
               d = DEPTH_W'($urandom_range(8000));
            end
            send_pixel(c, r, d, 1'b0, '0);
         end
      end

      wait_idle();
      if (mismatch_count == 0 && pending_writes.size() == 0) begin
         $display("depth_to_color_registration_core verification clean");
      end else begin
         $display("depth_to_color_registration_core verification failed");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/drc_pkg.sv
rtl/drc_if.sv
rtl/drc_csr.sv
rtl/drc_proj.sv
rtl/drc_div.sv
rtl/depth_to_color_registration_core.sv
rtl/drc_checker.sv
tb/tb_depth_to_color_registration_core.sv
